@@ hdl/kmwbc_pkg.sv @@
// Shared types and constants for the weighted bivariate distribution block.
package kmwbc_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int VAL_W       = FRAC_BITS + 1;
  localparam int COUNT_W     = 13;
  localparam int MAX_SAMPLES = 4096;
  localparam int TIME_W      = 32;
  localparam int M_W         = 17;
  localparam int M_FRAC      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int STEP_W      = $clog2(VAL_W);

  localparam logic [VAL_W-1:0]   FX_ONE  = VAL_W'(1) << FRAC_BITS;
  localparam logic [M_W-1:0]     M_ONE   = M_W'(1) << M_FRAC;
  localparam logic [COUNT_W-1:0] N_MAX   = COUNT_W'(MAX_SAMPLES);
  localparam logic [STEP_W-1:0]  DIV_LAST_STEP = STEP_W'(VAL_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SECOND = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] second_time;
    logic [M_W-1:0]    presmooth_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] probability;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_W,
    ST_MUL_S,
    ST_DONE
  } state_t;

endpackage

@@ hdl/km_weighted_bivariate_cdf.sv @@
// Top level: presmoothed Kaplan-Meier weighted bivariate distribution estimate.
// Each item runs through 25 divider steps, 2 shared-multiplier passes and 1 writeback;
//   the writeback waits only while a waiting result is stalled.
// Division is bit-serial restoring; no new item is taken until the last is written back.
// The input is stalled while an item is in work; a finished result may wait in the
//   output register meanwhile. Reset (synchronous, rst_n low): count 1, limits 0.
module km_weighted_bivariate_cdf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kmwbc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output kmwbc_pkg::out_item_t                out_data,
  input  logic                                cfg_wr_en,
  input  logic [kmwbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmwbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kmwbc_pkg::*;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] sample_count_r;
  logic [TIME_W-1:0]  limit_first_r;
  logic [TIME_W-1:0]  limit_second_r;

  logic [VAL_W-1:0]   surv_r;
  logic [VAL_W-1:0]   sum_r;
  logic [COUNT_W-1:0] idx_r;

  logic               hit_r;
  logic               last_r;
  logic [COUNT_W-1:0] divisor_r;
  logic [VAL_W-1:0]   quot_r;
  logic [COUNT_W-1:0] rem_r;
  logic [STEP_W-1:0]  step_r;
  logic [PROD_W-1:0]  prod_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               in_accept;
  logic               out_free;
  logic [COUNT_W-1:0] n_eff;
  logic               idx_over;
  logic [M_W-1:0]     m_sat;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   trial_diff;
  logic               trial_ge;
  logic [VAL_W-1:0]   mul_a;
  logic [VAL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [VAL_W-1:0]   prod_q;
  logic [VAL_W:0]     sum_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the configured run length into 1..MAX_SAMPLES
  always_comb begin
    priority if (sample_count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (sample_count_r > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = sample_count_r;
    end
  end

  assign idx_over = (idx_r >= n_eff);
  assign m_sat    = (in_data.presmooth_value > M_ONE) ? M_ONE : in_data.presmooth_value;

  // One restoring division step: shift in the next dividend bit
  assign trial      = {rem_r, quot_r[VAL_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor_r});
  assign trial_diff = trial - {1'b0, divisor_r};

  // Shared multiplier: weight pass, then survival pass
  always_comb begin
    mul_a = surv_r;
    mul_b = quot_r;
    if (state_r == ST_MUL_S) begin
      mul_b = FX_ONE - quot_r;
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_q  = prod_r[FRAC_BITS +: VAL_W];
  assign sum_ext = {1'b0, sum_r} + {1'b0, prod_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == DIV_LAST_STEP) begin
          state_nxt = ST_MUL_W;
        end
      end
      ST_MUL_W: state_nxt = ST_MUL_S;
      ST_MUL_S: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          hit_r     <= (in_data.first_time <= limit_first_r) &&
                       (in_data.second_time <= limit_second_r);
          last_r    <= idx_over || (idx_r + COUNT_W'(1) == n_eff);
          divisor_r <= idx_over ? COUNT_W'(1) : (n_eff - idx_r);
          quot_r    <= VAL_W'({m_sat, (FRAC_BITS - M_FRAC)'(0)});
          rem_r     <= '0;
          step_r    <= '0;
        end
      end
      ST_DIV: begin
        rem_r  <= trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quot_r <= {quot_r[VAL_W-2:0], trial_ge};
        step_r <= step_r + STEP_W'(1);
      end
      ST_MUL_W: prod_r <= mul_p;
      ST_MUL_S: prod_r <= mul_p;
      ST_DONE: ;
      default: ;
    endcase
  end

  // Run state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= COUNT_W'(1);
      limit_first_r  <= '0;
      limit_second_r <= '0;
      surv_r         <= FX_ONE;
      sum_r          <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SAMPLE_COUNT: begin
            sample_count_r <= cfg_wdata[COUNT_W-1:0];
            surv_r         <= FX_ONE;
            sum_r          <= '0;
            idx_r          <= '0;
          end
          REG_LIMIT_FIRST:  limit_first_r  <= cfg_wdata[TIME_W-1:0];
          REG_LIMIT_SECOND: limit_second_r <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      // prod_r holds the weight here; add it when the record falls in the box
      if (state_r == ST_MUL_S && hit_r) begin
        sum_r <= (sum_ext > {1'b0, FX_ONE}) ? FX_ONE : sum_ext[VAL_W-1:0];
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r            <= 1'b1;
        out_data_r.probability <= sum_r;
        out_data_r.last        <= last_r;
        if (last_r) begin
          surv_r <= FX_ONE;
          sum_r  <= '0;
          idx_r  <= '0;
        end else begin
          surv_r <= prod_q;
          idx_r  <= idx_r + COUNT_W'(1);
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_surv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    surv_r <= FX_ONE)
    else $error("survival product above 1.0");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= FX_ONE)
    else $error("probability sum above 1.0");

  a_factor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_W |-> quot_r <= FX_ONE)
    else $error("factor above 1.0 after division");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside writeback");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_W |-> $past(state_r) == ST_DIV && $past(step_r) == DIV_LAST_STEP)
    else $error("division ended early");

endmodule

@@ verif/km_weighted_bivariate_cdf_tb.sv @@
// Self-checking testbench for km_weighted_bivariate_cdf: directed and random records.
module km_weighted_bivariate_cdf_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmwbc_pkg::*;

  localparam longint unsigned ONE_FX = longint'(1) << FRAC_BITS;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Model of the estimator: configuration and run state
  logic [COUNT_W-1:0] run_len_reg = COUNT_W'(1);
  logic [TIME_W-1:0]  limit_first = '0;
  logic [TIME_W-1:0]  limit_second = '0;
  longint unsigned    survival = ONE_FX;
  longint unsigned    partial_prob = 0;
  int unsigned        record_pos = 0;

  out_item_t expected_partials[$];

  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int hold_off_cycles = 0;

  km_weighted_bivariate_cdf uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic longint unsigned fx_scale(input longint unsigned a,
                                               input longint unsigned b);
    if (a >= ONE_FX) return b;
    if (b >= ONE_FX) return a;
    return (a * b) >> FRAC_BITS;
  endfunction

  task automatic clear_run();
    survival     = ONE_FX;
    partial_prob = 0;
    record_pos   = 0;
  endtask

  // Advance the estimate by one record and queue the partial probability it yields
  task automatic estimate_record(input in_item_t rec);
    longint unsigned m;
    longint unsigned n;
    longint unsigned remaining;
    longint unsigned factor;
    longint unsigned weight;
    bit              closes_run;
    out_item_t       want;
    m = rec.presmooth_value;
    if (m > longint'(M_ONE)) m = M_ONE;
    n = run_len_reg;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    if (record_pos >= n) begin
      remaining  = 1;
      closes_run = 1'b1;
    end else begin
      remaining  = n - record_pos;
      closes_run = (record_pos + 1 == n);
    end
    factor = (m << FRAC_BITS) / (remaining << M_FRAC);
    if (factor > ONE_FX) factor = ONE_FX;
    weight   = fx_scale(factor, survival);
    survival = fx_scale(survival, ONE_FX - factor);
    if (rec.first_time <= limit_first && rec.second_time <= limit_second) begin
      partial_prob += weight;
      if (partial_prob > ONE_FX) partial_prob = ONE_FX;
    end
    want.probability = partial_prob[VAL_W-1:0];
    want.last        = closes_run;
    expected_partials.push_back(want);
    if (closes_run) clear_run();
    else record_pos++;
  endtask

  // Offer one item in bursts; when the current burst is used up, a gap opens if gap_max > 0
  task automatic send_record(input in_item_t rec);
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_data  = rec;
    do @(posedge clk); while (in_stall);
    estimate_record(rec);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_partials.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_SAMPLE_COUNT: begin
        run_len_reg = val[COUNT_W-1:0];
        clear_run();
      end
      REG_LIMIT_FIRST:  limit_first = val;
      REG_LIMIT_SECOND: limit_second = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [TIME_W-1:0] t1,
                                         input logic [TIME_W-1:0] t2,
                                         input logic [M_W-1:0] m);
    in_item_t rec;
    rec.first_time      = t1;
    rec.second_time     = t2;
    rec.presmooth_value = m;
    return rec;
  endfunction

  // Times cluster around the limit so both sides of the comparison get hit
  function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] lim);
    case ($urandom_range(7))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return lim;
      3:       return lim + 1;
      4:       return lim - $urandom_range(1, 1000);
      5:       return $urandom();
      default: return $urandom_range(lim);
    endcase
  endfunction

  function automatic logic [M_W-1:0] pick_presmooth();
    case ($urandom_range(9))
      0:       return '0;
      1:       return M_ONE;
      2:       return M_W'($urandom());
      3:       return M_ONE + M_W'($urandom_range(1, 64));
      default: return M_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TIME_MAX;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stall runs, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall = 1'b1;
      hold_off_cycles--;
    end else if (stall_run > 0) begin
      out_stall = 1'b1;
      stall_run--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall = 1'b1;
      stall_run = $urandom_range(0, 6);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_partials.size() == 0) begin
        report_mismatch("result with no record waiting", out_data.probability, 0);
      end else begin
        want = expected_partials.pop_front();
        if (out_data.probability !== want.probability)
          report_mismatch("probability", out_data.probability, want.probability);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Default registers: single-record runs, limits at zero
  task automatic test_reset_state();
    send_record(make_item('0, '0, M_ONE));
    send_record(make_item('0, '0, '0));
    send_record(make_item(TIME_W'(1), '0, M_ONE));
    send_record(make_item('0, TIME_MAX, '1));
    drain_results();
  endtask

  task automatic test_limit_extremes();
    write_reg(REG_LIMIT_FIRST, TIME_MAX);
    write_reg(REG_LIMIT_SECOND, TIME_MAX);
    write_reg(REG_SAMPLE_COUNT, '0);
    send_record(make_item(TIME_MAX, TIME_MAX, M_W'(17'h08000)));
    send_record(make_item('0, '0, '1));
    drain_results();
  endtask

  // Count above the maximum saturates; rewriting the count restarts the run mid-way
  task automatic test_count_extremes();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(8191));
    send_record(make_item(TIME_MAX, TIME_MAX, M_ONE));
    send_record(make_item('0, '0, '1));
    send_record(make_item('0, TIME_MAX, M_W'(1)));
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(MAX_SAMPLES));
    send_record(make_item('0, '0, M_ONE));
    send_record(make_item('0, '0, M_W'(17'h0ffff)));
    drain_results();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(3));
    send_record(make_item('0, '0, M_ONE));
    send_record(make_item(TIME_MAX, '0, M_W'(17'h08000)));
    send_record(make_item('0, '0, M_W'(1)));
    drain_results();
  endtask

  task automatic test_limit_edges();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(4));
    write_reg(REG_LIMIT_FIRST, CFG_DATA_W'(32'h8000_0000));
    write_reg(REG_LIMIT_SECOND, CFG_DATA_W'(32'h0000_1234));
    send_record(make_item(32'h8000_0000, 32'h0000_1234, M_W'(17'h0c000)));
    send_record(make_item(32'h8000_0001, 32'h0000_1234, M_ONE));
    send_record(make_item(32'h8000_0000, 32'h0000_1235, M_ONE));
    send_record(make_item(32'h7fff_ffff, 32'h0000_1233, M_ONE));
    drain_results();
  endtask

  task automatic test_random_runs();
    int sent;
    int batch;
    logic [CFG_DATA_W-1:0] n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       n = '0;
        1:       n = $urandom_range(MAX_SAMPLES + 1, 8191);
        2:       n = $urandom_range(13, 40);
        default: n = $urandom_range(1, 12);
      endcase
      // Sometimes keep the current run going across a limit change
      if ($urandom_range(3) != 0) write_reg(REG_SAMPLE_COUNT, n);
      write_reg(REG_LIMIT_FIRST, pick_limit());
      write_reg(REG_LIMIT_SECOND, pick_limit());
      gap_max   = $urandom_range(1) ? 0 : $urandom_range(1, 20);
      stall_pct = $urandom_range(1) ? 0 : $urandom_range(5, 70);
      batch = $urandom_range(20, 60);
      repeat (batch) begin
        send_record(make_item(pick_time(limit_first), pick_time(limit_second),
                              pick_presmooth()));
        sent++;
      end
      drain_results();
    end
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_output_hold();
    write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(5));
    write_reg(REG_LIMIT_FIRST, TIME_MAX);
    write_reg(REG_LIMIT_SECOND, TIME_MAX);
    gap_max   = 0;
    stall_pct = 0;
    hold_off_cycles = 300;
    repeat (20) send_record(make_item($urandom(), $urandom(), pick_presmooth()));
    drain_results();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_max   = 4;
    stall_pct = 20;
    test_reset_state();
    test_limit_extremes();
    test_count_extremes();
    test_limit_edges();
    test_output_hold();
    test_random_runs();

    drain_results();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/kmwbc_pkg.sv
hdl/km_weighted_bivariate_cdf.sv
verif/km_weighted_bivariate_cdf_tb.sv
